// ===== sv/wfifo_pkg.sv =====
package wfifo_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SMP_W = 16;
  localparam int WGT_W = SMP_W + CNT_W;
  localparam int LVL_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_AUDIO = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_SAMPLES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILL         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_WAKE_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_WAKE_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITER_ATTACHED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READER_ATTACHED  = 3'd5;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [1:0]       frame_kind;
    logic [SMP_W-1:0] sample_count;
    logic [31:0]      payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             is_full_now;
    logic             reader_wake;
    logic             reader_progress;
    logic             writer_wake;
    logic             writer_progress;
    logic             full_notice;
    logic             want_more;
    logic [31:0]      out_payload;
    logic [1:0]       out_kind;
    logic [SMP_W-1:0] out_sample_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0]      payload;
    logic [1:0]       kind;
    logic [SMP_W-1:0] samples;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// ===== sv/weighted_fifo_with_wakeup_watermarks.sv =====
// Frame-descriptor FIFO of 64 entries whose fill is counted in entries or in
// audio samples, with wakeup and progress notices to both sides. A request is
// read and then executed: the cycle it is accepted reads the head entry from the
// registered-read entry memory; the execute state then performs the operation and
// loads the response register. A response waiting in that register stalls the
// execute state, and no new request is accepted until it has executed. The
// configuration port is always ready and takes effect on the next cycle;
// write it only while no request is in flight. No clearing pass after reset.
module weighted_fifo_with_wakeup_watermarks (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  wfifo_pkg::req_t                 req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output wfifo_pkg::rsp_t                 rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wfifo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  import wfifo_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  wfifo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  wfifo_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

// ===== sv/wfifo_ram.sv =====
module wfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/wfifo_ctrl.sv =====
module wfifo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output wfifo_pkg::cmd_t cmd
);

  import wfifo_pkg::*;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free   = !rsp_valid || rsp_ready;
  assign req_ready   = (state == IDLE);
  assign cmd.capture = req_valid && req_ready;
  assign cmd.exec    = (state == EXEC) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd.exec || (rsp_valid && !rsp_ready);
      unique case (state)
        IDLE: begin
          if (cmd.capture) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == EXEC) && !req_ready)
    else $error("request accepted but no execute cycle follows");
`endif

endmodule

// ===== sv/wfifo_dp.sv =====
module wfifo_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  wfifo_pkg::cmd_t                    cmd,
  input  logic                               cfg_valid,
  input  logic [wfifo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_data,
  input  wfifo_pkg::req_t                    req,
  output wfifo_pkg::rsp_t                    rsp
);

  import wfifo_pkg::*;

  logic             size_in_samples;
  logic [LVL_W-1:0] max_fill;
  logic [LVL_W-1:0] read_wake_level;
  logic [LVL_W-1:0] write_wake_level;
  logic             writer_attached;
  logic             reader_attached;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [WGT_W-1:0] weight;
  logic [CNT_W-1:0] end_count;
  logic             reader_signaled;
  logic             writer_signaled;
  logic             armed;

  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;
  logic [WGT_W-1:0] weight_next;
  logic [CNT_W-1:0] end_count_next;
  logic             reader_signaled_next;
  logic             writer_signaled_next;
  logic             armed_next;
  rsp_t             rsp_next;

  req_t             req_q;
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             wr_en;

  logic [1:0]       kind_in;
  logic [WGT_W-1:0] w_in;
  logic [WGT_W-1:0] w_rd;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [WGT_W-1:0] weight_inc;
  logic [WGT_W-1:0] weight_dec;
  logic [CNT_W-1:0] end_inc;
  logic [CNT_W-1:0] end_dec;
  logic [LVL_W-1:0] fill_cur;
  logic [LVL_W-1:0] fill_push;
  logic [LVL_W-1:0] fill_pop;
  logic             full_cur;
  logic             full_push;
  logic             full_pop;
  logic             below;

  function automatic logic [LVL_W-1:0] fill_of(input logic sis, input logic [CNT_W-1:0] c,
                                               input logic [WGT_W-1:0] w);
    fill_of = sis ? LVL_W'(w) : LVL_W'(c);
  endfunction

  function automatic logic full_of(input logic [LVL_W-1:0] fill, input logic [LVL_W-1:0] mx,
                                   input logic [CNT_W-1:0] c);
    full_of = (fill >= mx) || (c >= CNT_W'(DEPTH));
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // entry memory, head entry read when a request is taken
  wfifo_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_entry),
    .rd_en   (cmd.capture),
    .rd_addr (head),
    .rd_data (rd_entry)
  );

  assign kind_in  = (req_q.frame_kind > KIND_END) ? KIND_OTHER : req_q.frame_kind;
  assign w_in     = (kind_in == KIND_AUDIO) ? WGT_W'(req_q.sample_count) : WGT_W'(1);
  assign w_rd     = (rd_entry.kind == KIND_AUDIO) ? WGT_W'(rd_entry.samples) : WGT_W'(1);

  assign count_inc  = count + CNT_W'(1);
  assign count_dec  = count - CNT_W'(1);
  assign weight_inc = weight + w_in;
  assign weight_dec = (weight >= w_rd) ? weight - w_rd : '0;
  assign end_inc    = end_count + CNT_W'(kind_in == KIND_END);
  assign end_dec    = (rd_entry.kind == KIND_END && end_count != '0) ?
                      end_count - CNT_W'(1) : end_count;

  assign fill_cur  = fill_of(size_in_samples, count, weight);
  assign fill_push = fill_of(size_in_samples, count_inc, weight_inc);
  assign fill_pop  = fill_of(size_in_samples, count_dec, weight_dec);
  assign full_cur  = full_of(fill_cur, max_fill, count);
  assign full_push = full_of(fill_push, max_fill, count_inc);
  assign full_pop  = full_of(fill_pop, max_fill, count_dec);
  assign below     = fill_cur < write_wake_level;

  assign wr_entry.payload = req_q.payload;
  assign wr_entry.kind    = kind_in;
  assign wr_entry.samples = req_q.sample_count;
  assign wr_en = cmd.exec && (req_q.opcode == OP_PUSH) && !full_cur;

  always_comb begin
    head_next            = head;
    tail_next            = tail;
    count_next           = count;
    weight_next          = weight;
    end_count_next       = end_count;
    reader_signaled_next = reader_signaled;
    writer_signaled_next = writer_signaled;
    armed_next           = armed;
    rsp_next             = '0;
    unique case (req_q.opcode)
      OP_PUSH: begin
        if (full_cur) begin
          rsp_next.status      = ST_FULL;
          rsp_next.is_full_now = 1'b1;
        end else begin
          tail_next      = ptr_inc(tail);
          count_next     = count_inc;
          weight_next    = weight_inc;
          end_count_next = end_inc;
          if (reader_attached && !reader_signaled) begin
            if ((below && fill_push >= write_wake_level) || end_inc != '0) begin
              rsp_next.reader_wake = 1'b1;
            end else begin
              rsp_next.reader_progress = 1'b1;
            end
            reader_signaled_next = 1'b1;
          end
          writer_signaled_next = 1'b0;
          if (armed && (full_push || end_inc != '0)) begin
            rsp_next.full_notice = 1'b1;
            armed_next           = 1'b0;
          end
          rsp_next.want_more   = !full_push;
          rsp_next.is_full_now = full_push;
        end
      end
      OP_POP: begin
        if (count == '0) begin
          rsp_next.status      = ST_EMPTY;
          rsp_next.is_full_now = full_cur;
        end else begin
          head_next                 = ptr_inc(head);
          count_next                = count_dec;
          weight_next               = weight_dec;
          end_count_next            = end_dec;
          rsp_next.out_payload      = rd_entry.payload;
          rsp_next.out_kind         = rd_entry.kind;
          rsp_next.out_sample_count = rd_entry.samples;
          if (writer_attached && !writer_signaled) begin
            if (fill_pop < read_wake_level) begin
              rsp_next.writer_wake = 1'b1;
            end else begin
              rsp_next.writer_progress = 1'b1;
            end
            writer_signaled_next = 1'b1;
          end
          reader_signaled_next = 1'b0;
          rsp_next.is_full_now = full_pop;
        end
      end
      OP_CHECK: begin
        armed_next           = !full_cur;
        rsp_next.is_full_now = full_cur;
      end
      OP_CLEAR: begin
        head_next            = '0;
        tail_next            = '0;
        count_next           = '0;
        weight_next          = '0;
        end_count_next       = '0;
        rsp_next.reader_wake = reader_attached;
        rsp_next.writer_wake = writer_attached;
        rsp_next.is_full_now = (max_fill == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_samples  <= 1'b0;
      max_fill         <= LVL_W'(1);
      read_wake_level  <= LVL_W'(1);
      write_wake_level <= LVL_W'(1);
      writer_attached  <= 1'b0;
      reader_attached  <= 1'b0;
      head             <= '0;
      tail             <= '0;
      count            <= '0;
      weight           <= '0;
      end_count        <= '0;
      reader_signaled  <= 1'b0;
      writer_signaled  <= 1'b0;
      armed            <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SIZE_IN_SAMPLES:  size_in_samples  <= cfg_data[0];
          CFG_MAX_FILL:         max_fill         <= cfg_data;
          CFG_READ_WAKE_LEVEL:  read_wake_level  <= cfg_data;
          CFG_WRITE_WAKE_LEVEL: write_wake_level <= cfg_data;
          CFG_WRITER_ATTACHED:  writer_attached  <= cfg_data[0];
          CFG_READER_ATTACHED:  reader_attached  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        head            <= head_next;
        tail            <= tail_next;
        count           <= count_next;
        weight          <= weight_next;
        end_count       <= end_count_next;
        reader_signaled <= reader_signaled_next;
        writer_signaled <= writer_signaled_next;
        armed           <= armed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("entry count above depth");
  assert property (@(posedge clk) disable iff (rst) end_count <= count)
    else $error("more end markers than entries");
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> (weight == '0))
    else $error("sample weight left on an empty queue");
`endif

endmodule

// ===== tb/sv/weighted_fifo_with_wakeup_watermarks_tb.sv =====
`timescale 1ns / 1ps

module weighted_fifo_with_wakeup_watermarks_tb;
  import wfifo_pkg::*;

  typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_SYNC, ACT_HOLD} act_t;

  typedef struct {
    act_t                 act;
    req_t                 item;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          val;
    int                   gap;
  } drive_act_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  drive_act_t pending_ops[$];
  rsp_t       pending_responses[$];
  bit         req_fire = 1'b0;
  bit         cfg_fire = 1'b0;
  bit         rx_idle_en = 1'b0;
  logic [31:0] hold_cycles = '0;
  int         rx_wait = 0;

  int mismatch_count = 0;
  int checked_count = 0;
  int refused_pushes = 0;
  int empty_pops = 0;
  int depth_fills = 0;
  int setting_count = 0;

  // fifo contents and counters as the block should hold them
  logic [31:0]      q_payload[DEPTH];
  logic [1:0]       q_kind[DEPTH];
  logic [SMP_W-1:0] q_samples[DEPTH];
  logic [PTR_W-1:0] q_head = '0;
  logic [PTR_W-1:0] q_tail = '0;
  int               q_count = 0;
  logic [63:0]      q_weight = '0;
  int               q_ends = 0;
  bit               rd_flagged = 1'b0;
  bit               wr_flagged = 1'b0;
  bit               notice_armed = 1'b0;

  bit          cfg_sample_mode = 1'b0;
  logic [31:0] cfg_max_fill = 32'd1;
  logic [31:0] cfg_rd_level = 32'd1;
  logic [31:0] cfg_wr_level = 32'd1;
  bit          cfg_writer_on = 1'b0;
  bit          cfg_reader_on = 1'b0;

  weighted_fifo_with_wakeup_watermarks i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] fill_level();
    return cfg_sample_mode ? q_weight : 64'(q_count);
  endfunction

  function automatic bit fifo_full();
    return fill_level() >= 64'(cfg_max_fill) || q_count >= DEPTH;
  endfunction

  function automatic logic [63:0] entry_weight(logic [1:0] kind, logic [SMP_W-1:0] samples);
    return (kind == KIND_AUDIO) ? 64'(samples) : 64'd1;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      CFG_SIZE_IN_SAMPLES:  cfg_sample_mode = data[0];
      CFG_MAX_FILL:         cfg_max_fill = data;
      CFG_READ_WAKE_LEVEL:  cfg_rd_level = data;
      CFG_WRITE_WAKE_LEVEL: cfg_wr_level = data;
      CFG_WRITER_ATTACHED:  cfg_writer_on = data[0];
      CFG_READER_ATTACHED:  cfg_reader_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t        o;
    logic [1:0]  k;
    logic [1:0]  pk;
    logic [63:0] w;
    bit          below;
    o = '0;
    k = (r.frame_kind > KIND_END) ? KIND_OTHER : r.frame_kind;
    case (r.opcode)
      OP_PUSH: begin
        if (fifo_full()) begin
          o.status = ST_FULL;
        end else begin
          below = fill_level() < 64'(cfg_wr_level);
          q_payload[q_tail] = r.payload;
          q_kind[q_tail] = k;
          q_samples[q_tail] = r.sample_count;
          q_tail = q_tail + 1'b1;
          q_count++;
          q_weight = q_weight + entry_weight(k, r.sample_count);
          if (k == KIND_END) q_ends++;
          if (cfg_reader_on && !rd_flagged) begin
            if ((below && fill_level() >= 64'(cfg_wr_level)) || q_ends != 0)
              o.reader_wake = 1'b1;
            else
              o.reader_progress = 1'b1;
            rd_flagged = 1'b1;
          end
          wr_flagged = 1'b0;
          if ((fifo_full() || q_ends != 0) && notice_armed) begin
            o.full_notice = 1'b1;
            notice_armed = 1'b0;
          end
          o.want_more = !fifo_full();
        end
      end
      OP_POP: begin
        if (q_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          pk = q_kind[q_head];
          w = entry_weight(pk, q_samples[q_head]);
          o.out_payload = q_payload[q_head];
          o.out_kind = pk;
          o.out_sample_count = q_samples[q_head];
          q_head = q_head + 1'b1;
          q_count--;
          q_weight = (q_weight >= w) ? q_weight - w : 64'd0;
          if (pk == KIND_END && q_ends != 0) q_ends--;
          if (cfg_writer_on && !wr_flagged) begin
            if (fill_level() < 64'(cfg_rd_level))
              o.writer_wake = 1'b1;
            else
              o.writer_progress = 1'b1;
            wr_flagged = 1'b1;
          end
          rd_flagged = 1'b0;
        end
      end
      OP_CHECK: begin
        notice_armed = !fifo_full();
      end
      OP_CLEAR: begin
        q_head = '0;
        q_tail = '0;
        q_count = 0;
        q_weight = '0;
        q_ends = 0;
        o.reader_wake = cfg_reader_on;
        o.writer_wake = cfg_writer_on;
      end
      default: ;
    endcase
    o.is_full_now = fifo_full();
    return o;
  endfunction

  function automatic string differing_fields(rsp_t a, rsp_t b);
    string s;
    s = "";
    if (a.status !== b.status) s = {s, " status"};
    if (a.is_full_now !== b.is_full_now) s = {s, " is_full_now"};
    if (a.reader_wake !== b.reader_wake) s = {s, " reader_wake"};
    if (a.reader_progress !== b.reader_progress) s = {s, " reader_progress"};
    if (a.writer_wake !== b.writer_wake) s = {s, " writer_wake"};
    if (a.writer_progress !== b.writer_progress) s = {s, " writer_progress"};
    if (a.full_notice !== b.full_notice) s = {s, " full_notice"};
    if (a.want_more !== b.want_more) s = {s, " want_more"};
    if (a.out_payload !== b.out_payload) s = {s, " out_payload"};
    if (a.out_kind !== b.out_kind) s = {s, " out_kind"};
    if (a.out_sample_count !== b.out_sample_count) s = {s, " out_sample_count"};
    return s;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t  want;
    string diff;
    req_fire = !rst && req_valid && req_ready;
    cfg_fire = !rst && cfg_valid && cfg_ready;
    if (cfg_fire) apply_register(cfg_index, cfg_data);
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("response with no request pending: %p", rsp);
      end else begin
        want = pending_responses.pop_front();
        diff = differing_fields(want, rsp);
        checked_count++;
        if (diff != "") begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response %0d wrong in%s: expected %p, got %p",
                     checked_count, diff, want, rsp);
        end
      end
    end
    if (req_fire) begin
      want = predict_response(req);
      if (req.opcode == OP_PUSH && want.status == ST_FULL) refused_pushes++;
      if (want.status == ST_EMPTY) empty_pops++;
      if (req.opcode == OP_PUSH && want.status == ST_DONE && q_count == DEPTH) depth_fills++;
      pending_responses.push_back(want);
    end
  end

  always @(negedge clk) begin : driver
    bit          nxt_req_valid;
    bit          nxt_cfg_valid;
    logic [31:0] nxt_hold;
    nxt_req_valid = req_valid && !req_fire;
    nxt_cfg_valid = cfg_valid && !cfg_fire;
    nxt_hold = '0;
    if (!rst && !nxt_req_valid && !nxt_cfg_valid && pending_ops.size() > 0) begin
      if (pending_ops[0].gap > 0) begin
        pending_ops[0].gap = pending_ops[0].gap - 1;
      end else begin
        case (pending_ops[0].act)
          ACT_REQ: begin
            req <= pending_ops[0].item;
            nxt_req_valid = 1'b1;
            void'(pending_ops.pop_front());
          end
          ACT_CFG: begin
            cfg_index <= pending_ops[0].idx;
            cfg_data <= pending_ops[0].val;
            nxt_cfg_valid = 1'b1;
            void'(pending_ops.pop_front());
          end
          ACT_SYNC: begin
            if (pending_responses.size() == 0) begin
              rx_idle_en <= pending_ops[0].val[0];
              void'(pending_ops.pop_front());
            end
          end
          ACT_HOLD: begin
            nxt_hold = pending_ops[0].val;
            void'(pending_ops.pop_front());
          end
          default: ;
        endcase
      end
    end
    req_valid <= nxt_req_valid;
    cfg_valid <= nxt_cfg_valid;
    hold_cycles <= nxt_hold;
  end

  always @(negedge clk) begin : receiver
    if (hold_cycles != 0)
      rx_wait = hold_cycles;
    else if (rx_wait > 0)
      rx_wait = rx_wait - 1;
    else if (rx_idle_en && $urandom_range(0, 5) == 0)
      rx_wait = $urandom_range(1, 14);
    rsp_ready <= !rst && rx_wait == 0;
  end

  function automatic int pick_gap(bit tx_idle);
    return (tx_idle && $urandom_range(0, 6) == 0) ? int'($urandom_range(1, 14)) : 0;
  endfunction

  task automatic add_req(logic [1:0] op, logic [1:0] kind, logic [SMP_W-1:0] samples,
                         logic [31:0] payload, int gap);
    drive_act_t a;
    a.act = ACT_REQ;
    a.item = '{opcode: op, frame_kind: kind, sample_count: samples, payload: payload};
    a.idx = '0;
    a.val = '0;
    a.gap = gap;
    pending_ops.push_back(a);
  endtask

  task automatic add_ctl(act_t act, logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drive_act_t a;
    a.act = act;
    a.item = '0;
    a.idx = idx;
    a.val = val;
    a.gap = 0;
    pending_ops.push_back(a);
  endtask

  // wait for the block to drain, then write every register
  task automatic configure(bit sample_mode, logic [31:0] max_fill, logic [31:0] rd_level,
                           logic [31:0] wr_level, bit writer_on, bit reader_on, bit rx_idle);
    logic [31:0] junk;
    junk = $urandom & ~32'd1;
    setting_count++;
    add_ctl(ACT_SYNC, '0, 32'(rx_idle));
    add_ctl(ACT_CFG, CFG_SIZE_IN_SAMPLES, junk | 32'(sample_mode));
    add_ctl(ACT_CFG, CFG_MAX_FILL, max_fill);
    add_ctl(ACT_CFG, CFG_READ_WAKE_LEVEL, rd_level);
    add_ctl(ACT_CFG, CFG_WRITE_WAKE_LEVEL, wr_level);
    add_ctl(ACT_CFG, CFG_WRITER_ATTACHED, (~junk) & ~32'd1 | 32'(writer_on));
    add_ctl(ACT_CFG, CFG_READER_ATTACHED, junk | 32'(reader_on));
  endtask

  task automatic add_fill(int count, bit tx_idle);
    for (int i = 0; i < count; i++)
      add_req(OP_PUSH, 2'($urandom_range(0, 3)), 16'($urandom), $urandom, pick_gap(tx_idle));
  endtask

  // runs of mostly pushes and mostly pops with the odd check and clear
  task automatic add_random(int count, int big_pct, bit tx_idle);
    bit         filling;
    int         roll;
    logic [1:0] op;
    logic [15:0] samples;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_CLEAR;
      else if (roll < 9) op = OP_CHECK;
      else if (roll < (filling ? 80 : 30)) op = OP_PUSH;
      else op = OP_POP;
      samples = ($urandom_range(0, 99) < big_pct) ? 16'($urandom) : 16'($urandom_range(0, 40));
      add_req(op, 2'($urandom_range(0, 3)), samples, $urandom, pick_gap(tx_idle));
    end
  endtask

  task automatic build_stimulus();
    // entry mode, small queue, both sides attached
    configure(1'b0, 32'd4, 32'd2, 32'd3, 1'b1, 1'b1, 1'b0);
    add_req(OP_POP, KIND_OTHER, '0, '0, 0);
    add_req(OP_CHECK, KIND_OTHER, '0, '0, 0);
    add_req(OP_PUSH, KIND_OTHER, 16'hFFFF, 32'hFFFF_FFFF, 0);
    add_req(OP_PUSH, KIND_AUDIO, 16'h0000, 32'h0000_0000, 0);
    add_req(OP_PUSH, 2'd3, 16'h1234, 32'hA5A5_A5A5, 0);
    add_req(OP_PUSH, KIND_END, 16'h0000, 32'h5A5A_5A5A, 0);
    add_req(OP_PUSH, KIND_OTHER, 16'h0001, 32'h1234_5678, 0);
    repeat (5) add_req(OP_POP, KIND_OTHER, '0, '0, 0);
    add_req(OP_PUSH, KIND_END, 16'h8000, 32'h8000_0001, 0);
    add_req(OP_CLEAR, KIND_OTHER, '0, '0, 0);
    add_req(OP_CHECK, KIND_OTHER, '0, '0, 0);
    // sample mode with watermarks
    configure(1'b1, 32'd100, 32'd50, 32'd60, 1'b1, 1'b1, 1'b0);
    add_req(OP_PUSH, KIND_AUDIO, 16'd40, 32'h0000_0040, 0);
    add_req(OP_PUSH, KIND_AUDIO, 16'd30, 32'h0000_0030, 0);
    add_req(OP_POP, KIND_OTHER, '0, '0, 0);
    add_req(OP_PUSH, KIND_AUDIO, 16'hFFFF, 32'hFFFF_0000, 0);
    add_req(OP_PUSH, KIND_OTHER, 16'd7, 32'h0000_FFFF, 0);
    add_req(OP_CHECK, KIND_OTHER, '0, '0, 0);
    repeat (2) add_req(OP_POP, KIND_OTHER, '0, '0, 0);
    add_req(OP_CLEAR, KIND_OTHER, '0, '0, 0);
    // zero thresholds
    configure(1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    add_req(OP_PUSH, KIND_AUDIO, 16'd5, 32'hDEAD_0005, 0);
    add_req(OP_POP, KIND_OTHER, '0, '0, 0);
    add_req(OP_CHECK, KIND_OTHER, '0, '0, 0);
    add_req(OP_CLEAR, KIND_OTHER, '0, '0, 0);

    // fill to full depth in entry mode
    configure(1'b0, 32'hFFFF_FFFF, 32'($urandom_range(1, 64)), 32'($urandom_range(1, 64)),
              1'b1, 1'b1, 1'b1);
    add_fill(70, 1'b1);
    add_random(40, 50, 1'b1);
    // receiver holds off while the sender keeps offering
    configure(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
    add_ctl(ACT_HOLD, '0, 32'd150);
    add_fill(30, 1'b0);
    add_random(40, 50, 1'b1);
    configure(1'b1, 32'($urandom_range(200, 5000)), 32'($urandom_range(0, 3000)),
              32'($urandom_range(0, 3000)), 1'($urandom), 1'($urandom), 1'b1);
    add_random(70, 5, 1'b1);
    configure(1'b0, 32'd8, 32'd3, 32'd4, 1'b1, 1'b0, 1'b0);
    add_random(60, 30, 1'b1);
    configure(1'b1, 32'd1, 32'd1, 32'd1, 1'b1, 1'b1, 1'b1);
    add_random(30, 20, 1'b0);
    // closing stretch with no idling on either side
    configure(1'b0, 32'd32, 32'($urandom_range(1, 32)), 32'($urandom_range(1, 32)),
              1'b1, 1'b1, 1'b0);
    add_random(60, 30, 1'b0);
  endtask

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || req_valid || pending_responses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    mismatch_count += pending_responses.size();
    $display("%0d requests checked over %0d register settings", checked_count, setting_count);
    $display("%0d pushes refused, %0d pops on empty queue, %0d fills to full depth",
             refused_pushes, empty_pops, depth_fills);
    if (mismatch_count == 0) begin
      $display("weighted_fifo_with_wakeup_watermarks: match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("weighted_fifo_with_wakeup_watermarks: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timed out with %0d responses outstanding", pending_responses.size());
    $display("weighted_fifo_with_wakeup_watermarks: mismatch");
    $finish;
  end

endmodule
